// ===== design/wlitu_pkg.sv =====
package wlitu_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 176;

  localparam logic [1:0] FN_STEP   = 2'd0;
  localparam logic [1:0] FN_REPORT = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic [2:0] CFG_BIN_COUNT   = 3'd0;
  localparam logic [2:0] CFG_MOVE_THRESH = 3'd1;
  localparam logic [2:0] CFG_GAIN_C      = 3'd2;
  localparam logic [2:0] CFG_INIT_MAG    = 3'd3;
  localparam logic [2:0] CFG_EQUIL       = 3'd4;
  localparam logic [2:0] CFG_SPREAD      = 3'd5;

  localparam logic [47:0] MAG_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [54:0] SUM_MAX = {55{1'b1}};
  localparam logic [62:0] SQ_MAX  = {63{1'b1}};

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_RDI, OP_RDJ, OP_CMP, OP_PRE, OP_MUL1, OP_MUL2,
    OP_DEN, OP_DINIT, OP_DIV, OP_DIVF, OP_SHARE, OP_URD, OP_UWR, OP_FIN,
    OP_RRD, OP_SQV, OP_SQ0, OP_SQ1, OP_SQ2, OP_ACC, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_RCLR, S_IDLE, S_FCLR, S_RDI, S_RDJ, S_CMP, S_PRE, S_MUL1, S_MUL2, S_DEN,
    S_DINIT, S_DIV, S_DIVF, S_SHARE, S_URD, S_UWR, S_FIN, S_RRD, S_SQV,
    S_SQ0, S_SQ1, S_SQ2, S_ACC, S_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic pre;
    logic den_zero;
    logic div_done;
    logic upd_last;
    logic rep_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/wlitu_ctrl.sv =====
module wlitu_ctrl import wlitu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] s_tuser,
  output logic       s_tready,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      S_RCLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          unique case (s_tuser)
            FN_STEP:   state_next = S_RDI;
            FN_REPORT: state_next = S_RRD;
            FN_CLEAR:  state_next = S_FCLR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_FCLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_DONE;
      end
      S_RDI: begin cmd.op = OP_RDI; state_next = S_RDJ; end
      S_RDJ: begin cmd.op = OP_RDJ; state_next = S_CMP; end
      S_CMP: begin
        cmd.op = OP_CMP;
        state_next = sts.pre ? S_PRE : S_MUL1;
      end
      S_PRE:   begin cmd.op = OP_PRE;  state_next = S_SHARE; end
      S_MUL1:  begin cmd.op = OP_MUL1; state_next = S_MUL2; end
      S_MUL2:  begin cmd.op = OP_MUL2; state_next = S_DEN; end
      S_DEN:   begin cmd.op = OP_DEN;  state_next = S_DINIT; end
      S_DINIT: begin
        cmd.op = OP_DINIT;
        state_next = sts.den_zero ? S_SHARE : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_next = S_DIVF;
      end
      S_DIVF:  begin cmd.op = OP_DIVF;  state_next = S_SHARE; end
      S_SHARE: begin cmd.op = OP_SHARE; state_next = S_URD; end
      S_URD:   begin cmd.op = OP_URD;   state_next = S_UWR; end
      S_UWR: begin
        cmd.op = OP_UWR;
        state_next = sts.upd_last ? S_FIN : S_URD;
      end
      S_FIN: begin cmd.op = OP_FIN; state_next = S_DONE; end
      S_RRD: begin cmd.op = OP_RRD; state_next = S_SQV; end
      S_SQV: begin cmd.op = OP_SQV; state_next = S_SQ0; end
      S_SQ0: begin cmd.op = OP_SQ0; state_next = S_SQ1; end
      S_SQ1: begin cmd.op = OP_SQ1; state_next = S_SQ2; end
      S_SQ2: begin cmd.op = OP_SQ2; state_next = S_ACC; end
      S_ACC: begin
        cmd.op = OP_ACC;
        state_next = sts.rep_last ? S_DONE : S_RRD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/wlitu_dp.sv =====
module wlitu_dp import wlitu_pkg::*; #(
  parameter int MAX_BINS  = 256,
  parameter int BIAS_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [39:0]      cfg_data,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW   = $clog2(MAX_BINS);
  localparam int IW   = (AW > 8) ? AW : 8;
  localparam int NW   = $clog2(MAX_BINS + 1);
  localparam int SW   = ((BIAS_BITS > 48) ? BIAS_BITS : 48) + 1;
  localparam int NUMW = 48 + NW + 16;
  localparam int DENW = 73;
  localparam int CW   = $clog2(NUMW + 1);

  logic [8:0]  bin_count;
  logic [16:0] move_threshold;
  logic [23:0] gain_c;
  logic [23:0] init_mag;
  logic [39:0] equil_steps;
  logic [15:0] spread_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count      <= 9'd10;
      move_threshold <= 17'd65536;
      gain_c         <= 24'd65536;
      init_mag       <= 24'd167772;
      equil_steps    <= 40'd100000;
      spread_frac    <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN_COUNT:   bin_count      <= cfg_data[8:0];
        CFG_MOVE_THRESH: move_threshold <= cfg_data[16:0];
        CFG_GAIN_C:      gain_c         <= cfg_data[23:0];
        CFG_INIT_MAG:    init_mag       <= cfg_data[23:0];
        CFG_EQUIL:       equil_steps    <= cfg_data;
        CFG_SPREAD:      spread_frac    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // bias store
  logic [BIAS_BITS-1:0] mem [MAX_BINS];
  logic [BIAS_BITS-1:0] rdata, wdata;
  logic [AW-1:0]        raddr, waddr;
  logic                 we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [15:0]          draw_r;
  logic [7:0]           tgt_r;
  logic [23:0]          acc_r;
  logic [IW-1:0]        walker;
  logic [BIAS_BITS-1:0] bi;
  logic [47:0]          a, p1, dlo, dhi, q, share, centre, step;
  logic [NUMW-1:0]      num;
  logic [DENW-1:0]      den;
  logic [DENW:0]        rem;
  logic                 over;
  logic [CW-1:0]        dcnt;
  logic [1:0]           u;
  logic [AW-1:0]        k, ccnt;
  logic [63:0]          v, pp0, px, py;
  logic [54:0]          sum;
  logic [62:0]          sq;
  logic [7:0]           res_bin;
  logic [47:0]          res_mag;
  logic [55:0]          res_sum;
  logic [62:0]          res_sq;

  // bins in use, clamped to 1..MAX_BINS
  logic [15:0]   n_w;
  logic [NW-1:0] n;
  logic [IW-1:0] nm1, wc, jj, uaddr;
  always_comb begin
    if (bin_count == 9'd0) n_w = 16'd1;
    else if ({7'd0, bin_count} > 16'(MAX_BINS)) n_w = 16'(MAX_BINS);
    else n_w = {7'd0, bin_count};
  end
  assign n   = NW'(n_w);
  assign nm1 = IW'(n_w - 16'd1);
  assign wc  = (walker > nm1) ? nm1 : walker;
  assign jj  = (IW'(tgt_r) > nm1) ? nm1 : IW'(tgt_r);

  logic [15:0] frac;
  logic        ok0, ok1;
  assign frac = (spread_frac > 16'd32768) ? 16'd32768 : spread_frac;
  assign ok0  = (frac != 16'd0) && (walker != '0);
  assign ok1  = (frac != 16'd0) && (walker < nm1);

  logic [63:0] share_p;
  logic [47:0] share_c;
  assign share_p = 64'(a) * 64'(frac);
  assign share_c = share_p[63:16];

  logic [47:0] uval;
  always_comb begin
    case (u)
      2'd0:    begin uaddr = walker - IW'(1); uval = share; end
      2'd1:    begin uaddr = walker + IW'(1); uval = share; end
      default: begin uaddr = walker;          uval = centre; end
    endcase
  end

  logic [SW-1:0]        ssum;
  logic [BIAS_BITS-1:0] sat_v;
  assign ssum  = SW'(rdata) + SW'(uval);
  assign sat_v = (ssum[SW-1:BIAS_BITS] != '0) ? {BIAS_BITS{1'b1}} : ssum[BIAS_BITS-1:0];

  logic [47:0] diff;
  assign diff = step - {8'd0, equil_steps};

  logic [DENW:0] rem_sh;
  logic          take;
  assign rem_sh = {rem[DENW-1:0], num[NUMW-1]};
  assign take   = rem_sh >= {1'b0, den};

  // acceptance test against the exponential draw
  logic [64:0] bdiff;
  logic        move_ok;
  assign bdiff   = 65'(rdata) - 65'(bi);
  assign move_ok = ({16'd0, draw_r} < move_threshold) &&
                   ((rdata < bi) || (bdiff < 65'({acc_r, 16'd0})));

  logic [127:0] psq;
  logic [62:0]  s2;
  logic [64:0]  sum_n;
  logic [63:0]  sq_n;
  logic [54:0]  sum_s;
  logic [62:0]  sq_s;
  assign psq   = {64'd0, pp0} + {31'd0, px, 33'd0} + {py, 64'd0};
  assign s2    = (psq[127:95] != '0) ? SQ_MAX : psq[94:32];
  assign sum_n = 65'(sum) + 65'(v);
  assign sq_n  = 64'(sq) + 64'(s2);
  assign sum_s = (sum_n > 65'(SUM_MAX)) ? SUM_MAX : sum_n[54:0];
  assign sq_s  = (sq_n > 64'(SQ_MAX)) ? SQ_MAX : sq_n[62:0];

  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we    = 1'b0;
    case (cmd.op)
      OP_CLR: begin we = 1'b1; waddr = ccnt; end
      OP_RDI: raddr = AW'(wc);
      OP_RDJ: raddr = AW'(jj);
      OP_URD: raddr = AW'(uaddr);
      OP_UWR: begin we = 1'b1; waddr = AW'(uaddr); wdata = sat_v; end
      OP_RRD: raddr = k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        draw_r  <= s_tdata[15:0];
        tgt_r   <= s_tdata[23:16];
        acc_r   <= s_tdata[47:24];
        res_bin <= (s_tuser == FN_CLEAR) ? 8'd0 : walker[7:0];
        res_mag <= '0;
        res_sum <= '0;
        res_sq  <= '0;
        sum     <= '0;
        sq      <= '0;
        k       <= '0;
      end
      OP_RDJ:  bi <= rdata;
      OP_PRE:  a <= 48'((64'(init_mag) * 64'(n)) << 8);
      OP_MUL1: begin
        p1  <= 48'(gain_c) * 48'(init_mag);
        dlo <= 48'(diff[23:0]) * 48'(init_mag);
      end
      OP_MUL2: begin
        num <= NUMW'(NUMW'(p1) * NUMW'(n)) << 16;
        dhi <= 48'(diff[47:24]) * 48'(init_mag);
      end
      OP_DEN:   den <= {1'b0, dhi, 24'd0} + DENW'(dlo) + DENW'({gain_c, 8'd0});
      OP_DINIT: begin
        rem  <= '0;
        q    <= '0;
        over <= 1'b0;
        dcnt <= '0;
        a    <= '0;
      end
      OP_DIV: begin
        rem  <= take ? rem_sh - {1'b0, den} : rem_sh;
        num  <= num << 1;
        q    <= {q[46:0], take};
        over <= over | q[47];
        dcnt <= dcnt + CW'(1);
      end
      OP_DIVF:  a <= over ? MAG_MAX : q;
      OP_SHARE: begin
        share  <= share_c;
        centre <= a - (ok0 ? share_c : 48'd0) - (ok1 ? share_c : 48'd0);
        u      <= ok0 ? 2'd0 : (ok1 ? 2'd1 : 2'd2);
      end
      OP_UWR:  u <= (u == 2'd0 && ok1) ? 2'd1 : 2'd2;
      OP_FIN: begin
        res_bin <= walker[7:0];
        res_mag <= a;
      end
      OP_SQV: v <= 64'(rdata);
      OP_SQ0: pp0 <= 64'(v[31:0]) * 64'(v[31:0]);
      OP_SQ1: px  <= 64'(v[31:0]) * 64'(v[63:32]);
      OP_SQ2: py  <= 64'(v[63:32]) * 64'(v[63:32]);
      OP_ACC: begin
        sum     <= sum_s;
        sq      <= sq_s;
        res_sum <= {1'b0, sum_s};
        res_sq  <= sq_s;
        k       <= k + AW'(1);
      end
      default: ;
    endcase
  end

  // walker, step count and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      walker <= '0;
      step   <= '0;
      ccnt   <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          ccnt <= '0;
          if (s_tuser == FN_CLEAR) begin
            walker <= '0;
            step   <= '0;
          end
        end
        OP_CLR: ccnt <= ccnt + AW'(1);
        OP_RDI: walker <= wc;
        OP_CMP: if (move_ok) walker <= jj;
        OP_FIN: if (step != MAG_MAX) step <= step + 48'd1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) m_tdata <= {1'b0, res_sq, res_sum, res_mag, res_bin};
  end

  assign sts.pre      = step < {8'd0, equil_steps};
  assign sts.den_zero = den == '0;
  assign sts.div_done = dcnt == CW'(NUMW - 1);
  assign sts.upd_last = u == 2'd2;
  assign sts.rep_last = IW'(k) == nm1;
  assign sts.clr_last = ccnt == AW'(MAX_BINS - 1);
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

// ===== design/wang_landau_inverse_time_update.sv =====
// Step item: before equilibration it reads, tests and updates; after it, it also
// runs the restoring divider over every numerator bit (73 at MAX_BINS = 256).
// Report item: each bin in use is read, squared from 32x32 products and summed.
// Clear item: sweeps the whole store to zero; one item is in work at a time.
// Reset: rst is synchronous, active high; the store is then swept to zero, and
// s_tready stays low until the sweep is done.
module wang_landau_inverse_time_update import wlitu_pkg::*; #(
  parameter int MAX_BINS  = 256,
  parameter int BIAS_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [39:0]      cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // move_draw, target_bin, accept_draw
  input  logic [1:0]       s_tuser,   // func
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // current_bin, magnitude, bias_sum, bias_square_sum
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wlitu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wlitu_dp #(
    .MAX_BINS  (MAX_BINS),
    .BIAS_BITS (BIAS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
